### rtl/afd_pkg.sv
`default_nettype none
package afd_pkg;

  localparam int CHANNELS   = 8;
  localparam int RING_DEPTH = 16;
  localparam int STATUS_LEN = 3;
  localparam int WORD_LEN   = 3;
  localparam int SAMPLE_W   = 24;
  localparam int IDX_W      = 3;
  localparam int QDEPTH     = 2;

  localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int WCH_W     = $clog2(CHANNELS + 1);
  localparam int SLOT_W    = $clog2(RING_DEPTH);
  localparam int QP_W      = $clog2(QDEPTH);
  localparam int QC_W      = $clog2(QDEPTH + 1);
  localparam int ROW_W     = CHANNELS * SAMPLE_W;
  localparam int FRAME_MIN = STATUS_LEN + WORD_LEN * CHANNELS;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  // One queued event: either a pop or a complete sample to push.
  typedef struct packed {
    logic             is_pop;
    logic             flag;
    logic [ROW_W-1:0] words;
  } evt_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SEND = 2'b10
  } back_state_t;

endpackage
`default_nettype wire

### rtl/afd_in_if.sv
`default_nettype none
interface afd_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] data_byte;
  logic       frame_end;

  modport source(output valid, command, data_byte, frame_end, input ready);
  modport sink(input valid, command, data_byte, frame_end, output ready);
endinterface
`default_nettype wire

### rtl/afd_out_if.sv
`default_nettype none
interface afd_out_if;
  logic               valid;
  logic               ready;
  logic               empty_res;
  logic [2:0]         channel_index;
  logic signed [23:0] sample_value;
  logic               config_flag;
  logic               last;

  modport source(output valid, empty_res, channel_index, sample_value, config_flag, last,
                 input ready);
  modport sink(input valid, empty_res, channel_index, sample_value, config_flag, last,
               output ready);
endinterface
`default_nettype wire

### rtl/adc_frame_deframer_fifo.sv
// ADC frame deframer with a sample ring.
// The in_ch channel carries one item per frame byte (command 0, with data_byte and a
// frame_end mark) or a pop request (command 1). Bytes are taken one per cycle and
// produce no result; the three status bytes are skipped, each channel word is built
// big-endian, and trailing CRC bytes are ignored. A frame that ends short is dropped.
// A complete frame is queued as one sample and written into a 16-slot ring that holds
// up to 15 samples; a sample that finds the ring full is lost.
// A pop returns on out_ch either a single empty result (empty_res and last set) or the
// oldest sample as one item per channel, in channel order, with last on the final one.
// A pop passes through the event queue; an empty result then goes into the output
// register, while a sample is read from the ring into a row register and its channels
// then follow one per cycle unless the receiver stalls. The back end takes no new event
// while it sends a sample; frame bytes keep flowing until the two-entry event queue
// fills. Only a pop or a frame-end byte of a complete frame waits for queue space.
// A receiver stall freezes the output register and, behind it, sends and empty-ring pops.
// cfg_we/cfg_data set the config_ok flag that each pushed sample records.
// Reset (rst_n low, synchronous) empties the ring and the queue and clears the
// config flag; no clearing pass is needed, so items are taken right after reset.
`default_nettype none
module adc_frame_deframer_fifo (
  input  wire logic clk,
  input  wire logic rst_n,
  afd_in_if.sink    in_ch,
  afd_out_if.source out_ch,
  input  wire logic cfg_we,
  input  wire logic cfg_data
);

  logic          cfg_ok_r;
  logic          fq_valid, fq_ready;
  afd_pkg::evt_t fq_evt;
  logic          qb_valid, qb_ready;
  afd_pkg::evt_t qb_evt;

  // The config flag is captured into every sample at the moment its frame ends.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_ok_r <= 1'b0;
    end else if (cfg_we) begin
      cfg_ok_r <= cfg_data;
    end
  end

  // Front end: byte assembly and classification of each item.
  afd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cfg_ok   (cfg_ok_r),
    .evt_valid(fq_valid),
    .evt_ready(fq_ready),
    .evt      (fq_evt)
  );

  // Short event queue that decouples byte intake from ring access.
  afd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (fq_valid),
    .in_ready (fq_ready),
    .in_evt   (fq_evt),
    .out_valid(qb_valid),
    .out_ready(qb_ready),
    .out_evt  (qb_evt)
  );

  // Back end: ring memory, push and pop execution, output register.
  afd_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .evt_valid(qb_valid),
    .evt_ready(qb_ready),
    .evt      (qb_evt),
    .out_ch   (out_ch)
  );

`ifndef SYNTH
  // An empty result always closes its pop and names channel zero.
  a_empty_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.empty_res) |-> (out_ch.last && out_ch.channel_index == 3'd0))
    else $error("empty result without last or with nonzero channel");

  // A sample result is marked last exactly on the final channel.
  a_last_channel: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.empty_res) |->
      (out_ch.last == (out_ch.channel_index == 3'(afd_pkg::CHANNELS - 1))))
    else $error("last marker out of step with channel index");

  // An item is taken while the queue is full only if it needs no queue entry.
  a_no_lost_event: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && !fq_ready) |-> !fq_valid)
    else $error("event accepted while the queue was full");
`endif

endmodule
`default_nettype wire

### rtl/afd_front.sv
`default_nettype none
module afd_front (
  input  wire logic   clk,
  input  wire logic   rst_n,
  afd_in_if.sink      in_ch,
  input  wire logic   cfg_ok,
  output logic        evt_valid,
  input  wire logic   evt_ready,
  output afd_pkg::evt_t evt
);

  logic [7:0]                     byte_cnt_r, byte_cnt_nxt;
  logic [15:0]                    partial_r, partial_nxt;
  logic [1:0]                     pos_r, pos_nxt;
  logic [afd_pkg::WCH_W-1:0]      wch_r, wch_nxt;
  logic [afd_pkg::SAMPLE_W-1:0]   buf_r [afd_pkg::CHANNELS];
  logic [afd_pkg::SAMPLE_W-1:0]   buf_nxt [afd_pkg::CHANNELS];

  logic [7:0] cnt_inc;
  logic       complete;
  logic       is_pop;
  logic       need_enq;
  logic       take;
  logic       in_word;

  always_comb begin
    cnt_inc  = (byte_cnt_r == 8'hFF) ? 8'hFF : byte_cnt_r + 8'd1;
    complete = ({1'b0, cnt_inc} >= 9'(afd_pkg::FRAME_MIN));
    is_pop   = (in_ch.command == afd_pkg::CMD_POP);
    need_enq = is_pop || (in_ch.frame_end && complete);
    in_ch.ready = evt_ready || !need_enq;
    take     = in_ch.valid && in_ch.ready;
    in_word  = ({1'b0, byte_cnt_r} >= 9'(afd_pkg::STATUS_LEN)) &&
               ({1'b0, wch_r} < (afd_pkg::WCH_W + 1)'(afd_pkg::CHANNELS));
  end

  always_comb begin
    byte_cnt_nxt = byte_cnt_r;
    partial_nxt  = partial_r;
    pos_nxt      = pos_r;
    wch_nxt      = wch_r;
    buf_nxt      = buf_r;
    if (take && !is_pop) begin
      if (in_word) begin
        case (pos_r)
          2'd0: begin
            partial_nxt = {in_ch.data_byte, 8'h00};
            pos_nxt     = 2'd1;
          end
          2'd1: begin
            partial_nxt = {partial_r[15:8], in_ch.data_byte};
            pos_nxt     = 2'd2;
          end
          default: begin
            buf_nxt[wch_r[afd_pkg::CH_W-1:0]] = {partial_r, in_ch.data_byte};
            pos_nxt = 2'd0;
            wch_nxt = wch_r + 1'b1;
          end
        endcase
      end
      byte_cnt_nxt = cnt_inc;
      if (in_ch.frame_end) begin
        byte_cnt_nxt = '0;
        partial_nxt  = '0;
        pos_nxt      = '0;
        wch_nxt      = '0;
      end
    end
  end

  // The pushed sample includes a word completed by the frame-end byte itself.
  always_comb begin
    evt_valid  = in_ch.valid && need_enq;
    evt.is_pop = is_pop;
    evt.flag   = cfg_ok;
    for (int i = 0; i < afd_pkg::CHANNELS; i++) begin
      evt.words[i*afd_pkg::SAMPLE_W +: afd_pkg::SAMPLE_W] = buf_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_cnt_r <= '0;
      partial_r  <= '0;
      pos_r      <= '0;
      wch_r      <= '0;
    end else begin
      byte_cnt_r <= byte_cnt_nxt;
      partial_r  <= partial_nxt;
      pos_r      <= pos_nxt;
      wch_r      <= wch_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
  end

endmodule
`default_nettype wire

### rtl/afd_queue.sv
`default_nettype none
module afd_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire afd_pkg::evt_t  in_evt,
  output logic                out_valid,
  input  wire logic           out_ready,
  output afd_pkg::evt_t       out_evt
);

  afd_pkg::evt_t              entry_r [afd_pkg::QDEPTH];
  logic [afd_pkg::QP_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [afd_pkg::QP_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [afd_pkg::QC_W-1:0]   count_r, count_nxt;
  logic                       push, pop;

  always_comb begin
    in_ready  = (count_r != afd_pkg::QC_W'(afd_pkg::QDEPTH));
    out_valid = (count_r != '0);
    out_evt   = entry_r[rd_ptr_r];
    push      = in_valid && in_ready;
    pop       = out_valid && out_ready;

    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == afd_pkg::QP_W'(afd_pkg::QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == afd_pkg::QP_W'(afd_pkg::QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= in_evt;
    end
  end

endmodule
`default_nettype wire

### rtl/afd_back.sv
`default_nettype none
module afd_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           evt_valid,
  output logic                evt_ready,
  input  wire afd_pkg::evt_t  evt,
  afd_out_if.source           out_ch
);

  // Ring rows hold the flag in the top bit above the channel words.
  logic [afd_pkg::ROW_W:0]        ring_mem [afd_pkg::RING_DEPTH];
  logic [afd_pkg::ROW_W-1:0]      row_words_r;
  logic                           row_flag_r;

  afd_pkg::back_state_t           state_r, state_nxt;
  logic [afd_pkg::SLOT_W-1:0]     wr_slot_r, wr_slot_nxt, wr_next;
  logic [afd_pkg::SLOT_W-1:0]     rd_slot_r, rd_slot_nxt, rd_next;
  logic [afd_pkg::CH_W-1:0]       ch_r, ch_nxt;

  logic                           out_valid_r, out_valid_nxt;
  logic                           out_empty_r, out_flag_r, out_last_r;
  logic [afd_pkg::IDX_W-1:0]      out_idx_r;
  logic [afd_pkg::SAMPLE_W-1:0]   out_val_r;

  logic free, ring_empty, take, do_write, pop_data, pop_empty, send_now, last_ch;

  always_comb begin
    free       = !out_valid_r || out_ch.ready;
    ring_empty = (rd_slot_r == wr_slot_r);
    wr_next    = (wr_slot_r == afd_pkg::SLOT_W'(afd_pkg::RING_DEPTH - 1)) ? '0
                                                                          : wr_slot_r + 1'b1;
    rd_next    = (rd_slot_r == afd_pkg::SLOT_W'(afd_pkg::RING_DEPTH - 1)) ? '0
                                                                          : rd_slot_r + 1'b1;
    evt_ready  = (state_r == afd_pkg::ST_IDLE) && (!evt.is_pop || !ring_empty || free);
    take       = evt_valid && evt_ready;
    do_write   = take && !evt.is_pop && (wr_next != rd_slot_r);
    pop_data   = take && evt.is_pop && !ring_empty;
    pop_empty  = take && evt.is_pop && ring_empty;
    send_now   = (state_r == afd_pkg::ST_SEND) && free;
    last_ch    = (ch_r == afd_pkg::CH_W'(afd_pkg::CHANNELS - 1));

    state_nxt   = state_r;
    wr_slot_nxt = do_write ? wr_next : wr_slot_r;
    rd_slot_nxt = pop_data ? rd_next : rd_slot_r;
    ch_nxt      = ch_r;
    case (state_r)
      afd_pkg::ST_IDLE: begin
        if (pop_data) begin
          state_nxt = afd_pkg::ST_SEND;
          ch_nxt    = '0;
        end
      end
      afd_pkg::ST_SEND: begin
        if (send_now) begin
          if (last_ch) begin
            state_nxt = afd_pkg::ST_IDLE;
          end else begin
            ch_nxt = ch_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = afd_pkg::ST_IDLE;
      end
    endcase

    out_valid_nxt = (out_valid_r && !out_ch.ready) || pop_empty || send_now;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= afd_pkg::ST_IDLE;
      wr_slot_r   <= '0;
      rd_slot_r   <= '0;
      ch_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wr_slot_r   <= wr_slot_nxt;
      rd_slot_r   <= rd_slot_nxt;
      ch_r        <= ch_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_write) begin
      ring_mem[wr_slot_r] <= {evt.flag, evt.words};
    end
    if (pop_data) begin
      {row_flag_r, row_words_r} <= ring_mem[rd_slot_r];
    end
  end

  always_ff @(posedge clk) begin
    if (pop_empty) begin
      out_empty_r <= 1'b1;
      out_idx_r   <= '0;
      out_val_r   <= '0;
      out_flag_r  <= 1'b0;
      out_last_r  <= 1'b1;
    end else if (send_now) begin
      out_empty_r <= 1'b0;
      out_idx_r   <= afd_pkg::IDX_W'(ch_r);
      out_val_r   <= row_words_r[ch_r*afd_pkg::SAMPLE_W +: afd_pkg::SAMPLE_W];
      out_flag_r  <= row_flag_r;
      out_last_r  <= last_ch;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.empty_res     = out_empty_r;
  assign out_ch.channel_index = out_idx_r;
  assign out_ch.sample_value  = $signed(out_val_r);
  assign out_ch.config_flag   = out_flag_r;
  assign out_ch.last          = out_last_r;

endmodule
`default_nettype wire

### bench/afd_result_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the deframer, keeps its own picture of the frame
// assembly and the sample ring, and compares every returned item against it.
module afd_result_checker
  import afd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  afd_in_if    in_ch,
  afd_out_if   out_ch,
  input  logic cfg_we,
  input  logic cfg_data,
  output int   fail_count,
  output int   pending
);

  typedef struct packed {
    logic               empty_res;
    logic [2:0]         channel_index;
    logic signed [23:0] sample_value;
    logic               config_flag;
    logic               last;
  } chan_result_t;

  chan_result_t due_results[$];

  logic [7:0]  byte_cnt;
  logic [15:0] hi_bytes;
  logic [23:0] frame_words[CHANNELS];
  logic [23:0] ring_words[RING_DEPTH][CHANNELS];
  logic        ring_flag[RING_DEPTH];
  int unsigned wr_slot;
  int unsigned rd_slot;
  logic        verdict_flag;

  // Follows one accepted item: a frame byte updates the assembly, a frame end
  // may push a sample, and a pop queues the results it must produce.
  task automatic deframe_item(input logic cmd, input logic [7:0] b, input logic fe);
    int unsigned offs;
    int unsigned ch;
    int unsigned next_slot;
    chan_result_t r;
    if (cmd == CMD_BYTE) begin
      if (byte_cnt >= STATUS_LEN) begin
        offs = byte_cnt - STATUS_LEN;
        ch   = offs / WORD_LEN;
        if (ch < CHANNELS) begin
          case (offs % WORD_LEN)
            0: hi_bytes = {b, 8'h00};
            1: hi_bytes = hi_bytes | {8'h00, b};
            default: frame_words[ch] = {hi_bytes, b};
          endcase
        end
      end
      if (byte_cnt != 8'hFF) byte_cnt = byte_cnt + 8'd1;
      if (fe) begin
        next_slot = (wr_slot + 1) % RING_DEPTH;
        if (byte_cnt >= FRAME_MIN && next_slot != rd_slot) begin
          for (int i = 0; i < CHANNELS; i++) ring_words[wr_slot][i] = frame_words[i];
          ring_flag[wr_slot] = verdict_flag;
          wr_slot = next_slot;
        end
        byte_cnt = '0;
        hi_bytes = '0;
      end
    end else if (rd_slot == wr_slot) begin
      r = '{empty_res: 1'b1, channel_index: 3'd0, sample_value: '0,
            config_flag: 1'b0, last: 1'b1};
      due_results.push_back(r);
    end else begin
      for (int i = 0; i < CHANNELS; i++) begin
        r.empty_res     = 1'b0;
        r.channel_index = i[2:0];
        r.sample_value  = ring_words[rd_slot][i];
        r.config_flag   = ring_flag[rd_slot];
        r.last          = (i == CHANNELS - 1);
        due_results.push_back(r);
      end
      rd_slot = (rd_slot + 1) % RING_DEPTH;
    end
  endtask

  task automatic compare_result();
    chan_result_t got;
    chan_result_t want;
    got = '{out_ch.empty_res, out_ch.channel_index, out_ch.sample_value,
            out_ch.config_flag, out_ch.last};
    if (due_results.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("[%0t] unexpected item: empty=%0b ch=%0d value=%0d flag=%0b last=%0b",
                 $realtime, got.empty_res, got.channel_index, got.sample_value,
                 got.config_flag, got.last);
    end else begin
      want = due_results.pop_front();
      if (got !== want) begin
        fail_count++;
        if (fail_count <= 10)
          $display({"[%0t] mismatch: expected empty=%0b ch=%0d value=%0d flag=%0b last=%0b,",
                    " got empty=%0b ch=%0d value=%0d flag=%0b last=%0b"}, $realtime,
                   want.empty_res, want.channel_index, want.sample_value,
                   want.config_flag, want.last, got.empty_res, got.channel_index,
                   got.sample_value, got.config_flag, got.last);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      byte_cnt     = '0;
      hi_bytes     = '0;
      wr_slot      = 0;
      rd_slot      = 0;
      verdict_flag = 1'b0;
      fail_count   = 0;
      due_results.delete();
    end else begin
      if (in_ch.valid && in_ch.ready)
        deframe_item(in_ch.command, in_ch.data_byte, in_ch.frame_end);
      if (out_ch.valid && out_ch.ready) compare_result();
      if (cfg_we) verdict_flag = cfg_data;
    end
    pending = due_results.size();
  end

endmodule

### bench/adc_frame_deframer_fifo_tb.sv
`timescale 1ns / 1ps

// Top of the deframer bench. It produces frames and pop requests, throttles the
// receiver, and gives the verdict; all prediction and comparison happens in
// the checker instantiated beside the block.
module adc_frame_deframer_fifo_tb;
  import afd_pkg::*;

  // Cycles without any accepted item before the run is declared hung. The
  // longest legal quiet stretch is a receiver stall or a sender gap or the
  // settling pause between phases, far below this.
  localparam int HANG_LIMIT = 3000;
  // Pause after the last expected item before a register write or the verdict.
  // A frame end with no pop behind it may still be moving through the event
  // queue into the ring.
  localparam int SETTLE_CYCLES = 40;

  // Channel words at and next to the extremes of the signed 24-bit range and of zero.
  localparam logic [23:0] CORNER_WORDS[CHANNELS] = '{
    24'h7FFFFF, 24'h800000, 24'h000000, 24'hFFFFFF,
    24'h000001, 24'hFFFFFE, 24'h800001, 24'h7FFFFE
  };

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_data;
  int   fail_count;
  int   pending;
  bit   steady;
  int   sent;

  afd_in_if  in_ch();
  afd_out_if out_ch();

  adc_frame_deframer_fifo DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data)
  );

  afd_result_checker checker_inst (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Idle lengths: mostly none or a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  // Hands one item to the block and returns at the edge where it was taken.
  // Valid stays high between back-to-back items, so it is never lowered and
  // raised again in the same time step.
  task automatic send_item(input logic cmd, input logic [7:0] b, input logic fe);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.command   <= cmd;
    in_ch.data_byte <= b;
    in_ch.frame_end <= fe;
    do @(posedge clk); while (!in_ch.ready);
    sent++;
  endtask

  task automatic send_pop();
    send_item(CMD_POP, 8'($urandom), 1'($urandom));
  endtask

  // Sends one frame of len bytes: three status bytes, then channel words in
  // big-endian order, then trailing bytes standing in for the CRC. With
  // corner set, the channel words are the CORNER_WORDS values. stray_pct is the
  // chance of a pop slipping in before each byte; such a pop may carry a
  // frame-end mark, which must not close the frame.
  task automatic send_frame(input int len, input bit corner, input int stray_pct);
    logic [23:0] words[CHANNELS];
    logic [7:0]  b;
    int          offs;
    for (int i = 0; i < CHANNELS; i++) begin
      if (corner) words[i] = CORNER_WORDS[i];
      else if ($urandom_range(0, 3) == 0) words[i] = CORNER_WORDS[$urandom_range(0, CHANNELS - 1)];
      else words[i] = 24'($urandom);
    end
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(0, 99) < stray_pct) send_pop();
      b = 8'($urandom);
      if (k >= STATUS_LEN && k < FRAME_MIN) begin
        offs = k - STATUS_LEN;
        b = words[offs / WORD_LEN][8 * (2 - offs % WORD_LEN) +: 8];
      end
      send_item(CMD_BYTE, b, k == len - 1);
    end
  endtask

  // Waits until every expected item has come back and the block has settled,
  // which is the only time the config register is touched.
  task automatic drain_and_settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_verdict(input logic v);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  // One random phase. Each operation is either a frame or a pop; the frame
  // share sets whether the ring tends to fill up or drain. Most frames are
  // complete and some end short. The phase stops once it has sent about
  // budget items.
  task automatic run_phase(input int budget, input int frame_pct, input int stray_pct);
    int r;
    int stop;
    stop = sent + budget;
    while (sent < stop) begin
      steady = ($urandom_range(0, 99) < 15);
      if ($urandom_range(0, 99) < frame_pct) begin
        r = $urandom_range(0, 99);
        if (r < 12) send_frame($urandom_range(1, FRAME_MIN - 1), 1'b0, stray_pct);
        else send_frame($urandom_range(FRAME_MIN, FRAME_MIN + 6), 1'b0, stray_pct);
      end else begin
        send_pop();
      end
    end
    steady = 1'b0;
  endtask

  // Receiver side: ready stays high for a random stretch, then drops for a
  // random gap, so stalls land on empty results and on every channel item.
  initial begin : receiver
    int hold;
    forever begin
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
      hold = pick_gap();
      if (hold > 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
    end
  end

  // Hang detection: any cycle that moves an item on either channel resets
  // the count.
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < HANG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle = 0;
      else idle++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_data        <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.command   <= CMD_BYTE;
    in_ch.data_byte <= 8'h00;
    in_ch.frame_end <= 1'b0;
    steady           = 1'b0;
    sent             = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_verdict(1'b0);

    // Directed part. Pops on an empty ring, one of them carrying a frame-end
    // mark, must each give a single empty item.
    send_item(CMD_POP, 8'h00, 1'b0);
    send_item(CMD_POP, 8'hFF, 1'b1);
    // An exactly complete frame with the corner channel words.
    send_frame(FRAME_MIN, 1'b1, 0);
    // A frame one byte short is thrown away.
    send_frame(FRAME_MIN - 1, 1'b0, 0);
    // A frame with CRC bytes and pops mixed in; the pops' frame-end marks
    // are ignored and the frame carries on.
    send_frame(FRAME_MIN + 4, 1'b0, 20);
    send_pop();
    send_pop();
    send_pop();
    drain_and_settle();

    // Random phases, switching the verdict flag in between: a mix that leans
    // toward frames, then one that leans toward pops.
    write_verdict(1'b1);
    run_phase(85, 60, 4);
    drain_and_settle();
    write_verdict(1'b0);
    run_phase(85, 45, 8);
    // Empty whatever is left in the ring so every stored sample is read once.
    for (int i = 0; i < RING_DEPTH; i++) send_pop();
    drain_and_settle();

    if (fail_count == 0 && pending == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

### adc_frame_deframer_fifo.f
rtl/afd_pkg.sv
rtl/afd_in_if.sv
rtl/afd_out_if.sv
rtl/afd_front.sv
rtl/afd_queue.sv
rtl/afd_back.sv
rtl/adc_frame_deframer_fifo.sv
bench/afd_result_checker.sv
bench/adc_frame_deframer_fifo_tb.sv
